/* rtl/hcbp_pkg.sv */
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

  localparam int unsigned ModeW = 2;
  localparam int unsigned SymW  = 8;
  localparam int unsigned CodeW = 20;
  localparam int unsigned LenW  = 5;
  localparam int unsigned ByteW = 8;
  // 7 pending bits plus a 20-bit code fit in four bytes
  localparam int unsigned WinW  = 32;

  localparam int unsigned MaxCodeLenDefault  = 20;
  localparam int unsigned SymbolCountDefault = 256;

  typedef enum logic [ModeW-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2
  } hcbp_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } hcbp_state_e;

  typedef struct packed {
    logic            we;
    logic            re;
    logic [SymW-1:0] addr;
    logic [LenW-1:0] wlen;
    logic [CodeW-1:0] wcode;
  } hcbp_mem_req_t;

  typedef struct packed {
    logic merge;
    logic flush;
    logic step;
  } hcbp_pack_ctrl_t;

  typedef struct packed {
    logic             pending;
    logic [1:0]       merge_bytes;
    logic [ByteW-1:0] cur_byte;
    logic             last;
  } hcbp_pack_stat_t;

endpackage

/* rtl/hcbp_if.sv */
// Valid/ready channel interfaces for symbol input and packed byte output.
interface hcbp_in_if;
  import hcbp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [SymW-1:0]  symbol;
  logic [CodeW-1:0] code_bits;
  logic [LenW-1:0]  code_length;

  modport source (output valid, mode, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, mode, symbol, code_bits, code_length, output ready);
endinterface

interface hcbp_out_if;
  import hcbp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] packed_byte;
  logic             last_of_run;

  modport source (output valid, packed_byte, last_of_run, input ready);
  modport sink   (input valid, packed_byte, last_of_run, output ready);
endinterface

/* rtl/hcbp_code_mem.sv */
// Code table memory: one write port, one synchronous read port.
module hcbp_code_mem #(
  parameter int unsigned SYMBOL_COUNT = hcbp_pkg::SymbolCountDefault
) (
  input  logic                          clk_i,
  input  hcbp_pkg::hcbp_mem_req_t       req_i,
  output logic [hcbp_pkg::LenW-1:0]     rd_len_o,
  output logic [hcbp_pkg::CodeW-1:0]    rd_code_o
);
  import hcbp_pkg::*;

  localparam int unsigned AddrW  = $clog2(SYMBOL_COUNT);
  localparam int unsigned EntryW = LenW + CodeW;

  logic [EntryW-1:0] mem [SYMBOL_COUNT];
  logic [EntryW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr[AddrW-1:0]] <= {req_i.wlen, req_i.wcode};
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr[AddrW-1:0]];
    end
  end

  assign rd_len_o  = rdata_q[EntryW-1:CodeW];
  assign rd_code_o = rdata_q[CodeW-1:0];

endmodule

/* rtl/hcbp_packer.sv */
// Bit accumulator, merge window and byte sequencer.
module hcbp_packer #(
  parameter int unsigned LEN_LIMIT = hcbp_pkg::CodeW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hcbp_pkg::hcbp_pack_ctrl_t     ctrl_i,
  input  logic [hcbp_pkg::LenW-1:0]     rd_len_i,
  input  logic [hcbp_pkg::CodeW-1:0]    rd_code_i,
  output hcbp_pkg::hcbp_pack_stat_t     stat_o
);
  import hcbp_pkg::*;

  logic [ByteW-1:0] acc_q, acc_d;
  logic [2:0]       pend_q, pend_d;
  logic [WinW-1:0]  win_q, win_d;
  logic [1:0]       nbytes_q, nbytes_d;
  logic [1:0]       idx_q, idx_d;

  logic [LenW-1:0]  clen;
  logic [CodeW-1:0] code_m;
  logic [5:0]       total;
  logic [5:0]       shamt;
  logic [WinW-1:0]  win;
  logic [ByteW-1:0] win_rest;

  // merge the looked-up code behind the pending bits, MSB first
  always_comb begin
    clen   = (rd_len_i > LenW'(LEN_LIMIT)) ? LenW'(LEN_LIMIT) : rd_len_i;
    code_m = rd_code_i & ~({CodeW{1'b1}} << clen);
    total  = 6'(pend_q) + 6'(clen);
    shamt  = 6'(WinW) - total;
    win    = {acc_q, {(WinW-ByteW){1'b0}}} | (WinW'(code_m) << shamt);
    case (total[4:3])
      2'd0:    win_rest = win[31:24];
      2'd1:    win_rest = win[23:16];
      2'd2:    win_rest = win[15:8];
      default: win_rest = win[7:0];
    endcase
  end

  always_comb begin
    acc_d    = acc_q;
    pend_d   = pend_q;
    win_d    = win_q;
    nbytes_d = nbytes_q;
    idx_d    = idx_q;
    if (ctrl_i.merge) begin
      win_d    = win;
      nbytes_d = total[4:3];
      idx_d    = '0;
      acc_d    = win_rest;
      pend_d   = total[2:0];
    end else if (ctrl_i.flush) begin
      win_d    = {acc_q, {(WinW-ByteW){1'b0}}};
      nbytes_d = 2'd1;
      idx_d    = '0;
      acc_d    = '0;
      pend_d   = '0;
    end else if (ctrl_i.step) begin
      idx_d    = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      pend_q   <= '0;
      nbytes_q <= '0;
      idx_q    <= '0;
    end else begin
      acc_q    <= acc_d;
      pend_q   <= pend_d;
      nbytes_q <= nbytes_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_comb begin
    stat_o.pending     = (pend_q != 3'd0);
    stat_o.merge_bytes = total[4:3];
    stat_o.last        = (idx_q == (nbytes_q - 2'd1));
    case (idx_q)
      2'd0:    stat_o.cur_byte = win_q[31:24];
      2'd1:    stat_o.cur_byte = win_q[23:16];
      2'd2:    stat_o.cur_byte = win_q[15:8];
      default: stat_o.cur_byte = win_q[7:0];
    endcase
  end

endmodule

/* rtl/huffman_code_bit_packer.sv */
// Huffman encoder back end: code table lookup and MSB-first byte packing.
// Load: taken back to back. Encode: registered code table read, lookup state
// merging the code, then emit state sending each completed byte (0..3) as the
// sink takes them. Flush: ends on the transfer if nothing is pending, else the
// emit state sends one padded byte. Reset clears the accumulator, pending count
// and handshake state at once; the code table is not cleared.
module huffman_code_bit_packer #(
  parameter int unsigned MAX_CODE_LEN = hcbp_pkg::MaxCodeLenDefault,
  parameter int unsigned SYMBOL_COUNT = hcbp_pkg::SymbolCountDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hcbp_in_if.sink       in_i,
  hcbp_out_if.source    out_o
);
  import hcbp_pkg::*;

  // stored and used code length never exceeds the code field width
  localparam int unsigned LenLimit = (MAX_CODE_LEN < CodeW) ? MAX_CODE_LEN : CodeW;

  hcbp_state_e      state_q, state_d;
  hcbp_mem_req_t    mem_req;
  hcbp_pack_ctrl_t  pack_ctrl;
  hcbp_pack_stat_t  pack_stat;
  logic [LenW-1:0]  rd_len;
  logic [CodeW-1:0] rd_code;

  logic             in_fire;
  logic             sym_ok;
  logic             emit_fire;
  logic [LenW-1:0]  load_len;

  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_last_q;

  // Input is taken only in idle; table write and read issue on the transfer
  // itself, so a load always lands before any later lookup.
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign sym_ok     = ({1'b0, in_i.symbol} < (SymW+1)'(SYMBOL_COUNT));
  assign load_len   = (in_i.code_length > LenW'(LenLimit)) ? LenW'(LenLimit)
                                                           : in_i.code_length;

  // Output register frees up when the sink takes the held byte.
  assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_i.mode)
            MODE_ENCODE: if (sym_ok)            state_d = ST_LOOKUP;
            MODE_FLUSH:  if (pack_stat.pending) state_d = ST_EMIT;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOOKUP: begin
        // zero completed bytes means the item ends here without a transfer
        state_d = (pack_stat.merge_bytes != 2'd0) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (emit_fire && pack_stat.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_req.we      = in_fire && (in_i.mode == MODE_LOAD) && sym_ok;
    mem_req.re      = in_fire && (in_i.mode == MODE_ENCODE) && sym_ok;
    mem_req.addr    = in_i.symbol;
    mem_req.wlen    = load_len;
    mem_req.wcode   = in_i.code_bits;
    pack_ctrl.merge = (state_q == ST_LOOKUP);
    pack_ctrl.flush = in_fire && (in_i.mode == MODE_FLUSH) && pack_stat.pending;
    pack_ctrl.step  = emit_fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_byte_q <= pack_stat.cur_byte;
      out_last_q <= pack_stat.last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.packed_byte = out_byte_q;
  assign out_o.last_of_run = out_last_q;

  hcbp_code_mem #(
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_code_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_len_o  (rd_len),
    .rd_code_o (rd_code)
  );

  hcbp_packer #(
    .LEN_LIMIT (LenLimit)
  ) u_packer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (pack_ctrl),
    .rd_len_i  (rd_len),
    .rd_code_i (rd_code),
    .stat_o    (pack_stat)
  );

endmodule

/* rtl/hcbp_checker.sv */
// Port-level checks for the Huffman code bit packer, bound to the top level.
module hcbp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic [hcbp_pkg::ModeW-1:0]   in_mode_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [hcbp_pkg::ByteW-1:0]   out_byte_i,
  input logic                         out_last_i
);
  import hcbp_pkg::*;

  // held output must not change until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("output changed while stalled");

  // a table load never holds off the next item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i == MODE_LOAD) |=> in_ready_i)
    else $error("input stalled after a table load");

  // more bytes of the same item still to come: no new input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready while an item is still emitting");

  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.packed_byte),
  .out_last_i  (out_o.last_of_run)
);

/* test/huffman_code_bit_packer_tb.sv */
// Self-checking testbench for the Huffman code bit packer: table loads, encodes, flushes.
module huffman_code_bit_packer_tb;
  import hcbp_pkg::*;

  // Mode code the block must ignore.
  localparam logic [ModeW-1:0] ModeReserved = 2'd3;

  // Stored code lengths saturate at the smaller of the cap and the code field width.
  localparam int unsigned CodeLenCap =
      (MaxCodeLenDefault < CodeW) ? MaxCodeLenDefault : CodeW;

  // Cycles to wait after the last expected byte, so that items that make no byte
  // are also finished.
  localparam int unsigned DrainCycles = 16;

  // Hard stop. The slowest run is roughly 450 items, each with a possible sender gap,
  // its time in the block and up to 3 bytes that each wait out a receiver stall;
  // this bound is many times that.
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } packed_out_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hcbp_in_if  in_ch ();
  hcbp_out_if out_ch ();

  huffman_code_bit_packer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state: code table, which entries hold a code, and the partial byte.
  logic [LenW-1:0]  code_len_tbl  [SymbolCountDefault];
  logic [CodeW-1:0] code_word_tbl [SymbolCountDefault];
  bit               entry_loaded  [SymbolCountDefault];
  int unsigned      loaded_syms   [$];
  logic [ByteW-1:0] acc_byte;
  int unsigned      acc_count;

  // Bytes the block still owes, oldest first.
  packed_out_t expected_bytes [$];

  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Idle controls: sender gaps and receiver stalls.
  bit in_idle_en  = 1'b1;
  bit out_stall_en = 1'b1;

  // Work out what one accepted item produces and update the predictor state.
  function automatic void predict_packing(logic [ModeW-1:0] mode, logic [SymW-1:0] sym,
                                          logic [CodeW-1:0] bits, logic [LenW-1:0] len);
    int unsigned eff_len;
    int unsigned nbytes;
    packed_out_t tail;
    eff_len = 0;
    nbytes  = 0;
    case (mode)
      MODE_LOAD: begin
        eff_len = (len > CodeLenCap) ? CodeLenCap : len;
        code_len_tbl[sym]  = eff_len[LenW-1:0];
        code_word_tbl[sym] = bits;
        if (!entry_loaded[sym]) loaded_syms.push_back(sym);
        entry_loaded[sym] = 1'b1;
      end
      MODE_ENCODE: begin
        eff_len = code_len_tbl[sym];
        // First code bit is the most significant of the stored length.
        for (int i = int'(eff_len) - 1; i >= 0; i--) begin
          acc_byte[7 - acc_count] = code_word_tbl[sym][i];
          acc_count++;
          if (acc_count == 8) begin
            expected_bytes.push_back('{data: acc_byte, last: 1'b0});
            nbytes++;
            acc_byte  = '0;
            acc_count = 0;
          end
        end
        if (nbytes > 0) begin
          tail = expected_bytes.pop_back();
          tail.last = 1'b1;
          expected_bytes.push_back(tail);
        end
      end
      MODE_FLUSH: begin
        if (acc_count != 0) begin
          expected_bytes.push_back('{data: acc_byte, last: 1'b1});
          acc_byte  = '0;
          acc_count = 0;
        end
      end
      default: ;  // reserved mode: no effect
    endcase
  endfunction

  // Present one item, hold it until the transfer, then predict its bytes.
  // Valid is left high; a sender gap in the next call or the drain lowers it.
  task automatic send_item(logic [ModeW-1:0] mode, logic [SymW-1:0] sym,
                           logic [CodeW-1:0] bits, logic [LenW-1:0] len);
    if (in_idle_en && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.symbol      <= sym;
    in_ch.code_bits   <= bits;
    in_ch.code_length <= len;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_packing(mode, sym, bits, len);
  endtask

  // Encode and flush carry code fields the block does not use; keep them random.
  task automatic send_encode(logic [SymW-1:0] sym);
    send_item(MODE_ENCODE, sym, CodeW'($urandom), LenW'($urandom));
  endtask

  task automatic send_flush();
    send_item(MODE_FLUSH, SymW'($urandom), CodeW'($urandom), LenW'($urandom));
  endtask

  // Flush with nothing pending right after reset: no byte.
  task automatic test_flush_empty();
    send_flush();
  endtask

  // Table entries at the field extremes, saturation and ignored upper code bits.
  task automatic test_table_extremes();
    send_item(MODE_LOAD, 8'd0,   20'hFFFFF, 5'd20);
    send_item(MODE_LOAD, 8'd255, 20'hA5A5A, 5'd20);
    send_item(MODE_LOAD, 8'd1,   20'h00001, 5'd1);
    send_item(MODE_LOAD, 8'd2,   20'hFFFFF, 5'd0);   // zero length
    send_item(MODE_LOAD, 8'd3,   20'h5A5A5, 5'd31);  // saturates to the cap
    send_item(MODE_LOAD, 8'd4,   20'hFFFF3, 5'd4);   // only 0011 is the code
    send_item(MODE_LOAD, 8'd128, 20'h00000, 5'd20);
  endtask

  // Codes that cross two and three byte boundaries, plus zero-length and
  // flush with and without pending bits.
  task automatic test_byte_spanning();
    send_encode(8'd1);    // 1 bit pending
    send_encode(8'd2);    // nothing appended
    send_encode(8'd255);  // 21 bits: two bytes
    send_encode(8'd0);    // 25 bits: three bytes
    send_encode(8'd4);
    send_encode(8'd128);  // 25 bits: three bytes
    send_encode(8'd3);
    send_flush();         // partial byte, zero padded
    send_flush();         // nothing pending
  endtask

  // Reserved mode with every field bit set must leave the state alone.
  task automatic test_reserved_mode();
    send_encode(8'd1);
    send_item(ModeReserved, 8'hFF, 20'hFFFFF, 5'h1F);
    send_encode(8'd4);
    send_flush();
  endtask

  // Mostly well-formed traffic: loads, encodes of loaded symbols, flushes;
  // reserved-mode noise does not count toward the item total.
  task automatic test_random_traffic(int unsigned n_items, bit idling);
    int unsigned done_cnt;
    int unsigned pick;
    logic [LenW-1:0] len;
    done_cnt     = 0;
    in_idle_en   = idling;
    out_stall_en = idling;
    while (done_cnt < n_items) begin
      pick = $urandom_range(99);
      if (loaded_syms.size() == 0 || pick < 20) begin
        // Mostly legal lengths, sometimes anything the field holds.
        len = ($urandom_range(99) < 85) ? LenW'($urandom_range(1, CodeLenCap))
                                        : LenW'($urandom_range(0, 31));
        send_item(MODE_LOAD, SymW'($urandom_range(255)), CodeW'($urandom), len);
        done_cnt++;
      end else if (pick < 80) begin
        send_encode(SymW'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]));
        done_cnt++;
      end else if (pick < 95) begin
        send_flush();
        done_cnt++;
      end else begin
        send_item(ModeReserved, SymW'($urandom), CodeW'($urandom), LenW'($urandom));
      end
    end
    in_idle_en   = 1'b1;
    out_stall_en = 1'b1;
  endtask

  // Stop sending, wait for every owed byte, then let trailing work settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Receiver: check each transfer against the oldest owed byte, then pick the
  // next cycle's ready.
  initial begin
    packed_out_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual byte %02h last %0b",
                   $time, out_ch.packed_byte, out_ch.last_of_run);
          error_cnt++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_ch.packed_byte !== want.data) begin
            $display("%0t: packed_byte expected %02h actual %02h",
                     $time, want.data, out_ch.packed_byte);
            error_cnt++;
          end
          if (out_ch.last_of_run !== want.last) begin
            $display("%0t: last_of_run expected %0b actual %0b",
                     $time, want.last, out_ch.last_of_run);
            error_cnt++;
          end
        end
      end
      out_ch.ready <= out_stall_en ? ($urandom_range(99) >= 30) : 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    acc_byte  = '0;
    acc_count = 0;
    foreach (entry_loaded[i]) entry_loaded[i] = 1'b0;
    rst_ni            <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_LOAD;
    in_ch.symbol      <= '0;
    in_ch.code_bits   <= '0;
    in_ch.code_length <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_flush_empty();
    test_table_extremes();
    test_byte_spanning();
    test_reserved_mode();
    test_random_traffic(140, 1'b1);
    test_random_traffic(100, 1'b0);  // back-to-back stretch
    test_random_traffic(140, 1'b1);
    wait_drained();

    if (error_cnt == 0 && expected_bytes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/hcbp_pkg.sv
rtl/hcbp_if.sv
rtl/hcbp_code_mem.sv
rtl/hcbp_packer.sv
rtl/huffman_code_bit_packer.sv
rtl/hcbp_checker.sv
test/huffman_code_bit_packer_tb.sv
